// File: sv/pdcrc_pkg.sv
// ----------------------------------------------------------------------------
// pdcrc_pkg
// Constants shared by the packet descrambler: scrambling masks, swap pattern
// codes and the CRC-12 column function.
// ----------------------------------------------------------------------------
package pdcrc_pkg;

  localparam int unsigned BlockW   = 56;
  localparam int unsigned WordW    = 48;
  localparam int unsigned CrcW     = 12;
  localparam int unsigned CrcBits  = 44;
  localparam int unsigned RotW     = 6;

  localparam logic [CrcW-1:0] CrcPoly = 12'h885;
  localparam logic [CrcW-1:0] CrcTop  = 12'h800;
  localparam logic [CrcW-1:0] CrcMask = 12'hFFF;

  // Nibble swap pattern, from bits 3 and 1 of byte 6
  localparam logic [1:0] SwapLow  = 2'b00;
  localparam logic [1:0] SwapBit1 = 2'b01;
  localparam logic [1:0] SwapBit3 = 2'b10;

  typedef logic [BlockW-1:0] block_t;
  typedef logic [7:0]        byte_t;

  localparam block_t FirstMask [8] = '{
    56'h29C83989_20C383,
    56'h4838A92D_198145,
    56'hC1A18367_A8AB81,
    56'h82DAB184_C84722,
    56'h696939BC_41263C,
    56'hA4136129_896256,
    56'h4C312316_234DD3,
    56'h2554B34A_D66529
  };

  localparam block_t FinalMask = 56'h73C16908_12A64B;

  // CRC remainder contributed by a single set data bit at position k (MSB first)
  function automatic logic [CrcW-1:0] crc_col(input int unsigned k);
    logic [CrcW-1:0] crc;
    logic            dbit;
    logic            cbit;
    crc = '0;
    for (int unsigned i = 0; i < CrcBits; i++) begin
      dbit = (i == k);
      cbit = |(crc & CrcTop);
      crc  = (crc << 1) & CrcMask;
      if (dbit != cbit) begin
        crc = crc ^ CrcPoly;
      end
    end
    return crc;
  endfunction

endpackage

// File: sv/rf_packet_descrambler_crc12.sv
// ----------------------------------------------------------------------------
// rf_packet_descrambler_crc12
// Descrambles a 7-byte radio payload and checks its CRC-12.
// ----------------------------------------------------------------------------
// One transaction per cycle is taken on the input and one result per cycle is
// given on the output when not stalled. An input register feeds one
// pass of mask, nibble swap, 48-bit rotate, final mask and a CRC-12 XOR tree
// into the result register. A stall on the output holds the result register;
// the input register still takes one more transaction, so the input stalls
// only when both stages are full and the output is stalled.
module rf_packet_descrambler_crc12 (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [55:0]                cipher_block,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [23:0]                serial_number,
  output logic [7:0]                 status_byte,
  output logic [7:0]                 window_high,
  output logic [7:0]                 window_low,
  output logic [7:0]                 check_byte,
  output logic                       crc_ok
);

  logic                       s1_valid;
  pdcrc_pkg::block_t          s1_block;
  logic                       out_advance;
  logic                       in_accept;

  pdcrc_pkg::byte_t           b [7];
  logic [2:0]                 sel;
  logic [3:0]                 nib;
  logic [7:0]                 rot_a;
  logic [7:0]                 rot_b;
  logic [6:0]                 rot_c;
  logic [pdcrc_pkg::RotW-1:0] rot;
  logic [pdcrc_pkg::WordW-1:0]   word;
  logic [2*pdcrc_pkg::WordW-1:0] dbl;
  pdcrc_pkg::block_t          res;
  logic [pdcrc_pkg::CrcW-1:0] crc;
  logic                       crc_ok_next;

  assign out_advance = !(out_valid && out_stall);
  assign in_stall    = s1_valid && !out_advance;
  assign in_accept   = in_valid && !in_stall;

  always_comb begin
    sel = {s1_block[52], s1_block[34], s1_block[12]};
    for (int k = 0; k < 7; k++) begin
      b[k] = s1_block[8*(6-k) +: 8] ^ pdcrc_pkg::FirstMask[sel][8*(6-k) +: 8];
    end

    nib = b[6][7:4];
    unique case ({b[6][3], b[6][1]})
      pdcrc_pkg::SwapLow: begin
        b[6][7:4] = b[0][3:0];
        b[0][3:0] = nib;
        nib       = b[5][3:0];
        b[5][3:0] = b[3][3:0];
        b[3][3:0] = nib;
      end
      pdcrc_pkg::SwapBit1: begin
        b[6][7:4] = b[0][7:4];
        b[0][7:4] = nib;
        nib       = b[4][7:4];
        b[4][7:4] = b[1][7:4];
        b[1][7:4] = nib;
      end
      pdcrc_pkg::SwapBit3: begin
        b[6][7:4] = b[5][7:4];
        b[5][7:4] = nib;
        nib       = b[5][3:0];
        b[5][3:0] = b[2][7:4];
        b[2][7:4] = nib;
      end
      default: begin
        b[6][7:4] = b[1][3:0];
        b[1][3:0] = nib;
        nib       = b[4][7:4];
        b[4][7:4] = b[3][3:0];
        b[3][3:0] = nib;
      end
    endcase

    // reduce byte 6 mod 48
    rot_a = b[6];
    rot_b = (rot_a >= 8'd192) ? (rot_a - 8'd192) : rot_a;
    rot_c = (rot_b >= 8'd96) ? 7'(rot_b - 8'd96) : 7'(rot_b);
    rot   = (rot_c >= 7'd48) ? 6'(rot_c - 7'd48) : 6'(rot_c);

    word = {b[0], b[1], b[2], b[3], b[4], b[5]};
    dbl  = {word, word} >> rot;
    res  = {dbl[pdcrc_pkg::WordW-1:0], b[6]} ^ pdcrc_pkg::FinalMask;

    crc = '0;
    for (int unsigned k = 0; k < pdcrc_pkg::CrcBits; k++) begin
      if (res[pdcrc_pkg::BlockW-1-k]) begin
        crc = crc ^ pdcrc_pkg::crc_col(k);
      end
    end
    crc_ok_next = (crc == res[pdcrc_pkg::CrcW-1:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid <= in_valid;
      end
      if (out_advance) begin
        out_valid <= s1_valid;
      end
    end
    if (in_accept) begin
      s1_block <= cipher_block;
    end
    if (out_advance && s1_valid) begin
      serial_number <= res[55:32];
      status_byte   <= res[31:24];
      window_high   <= res[23:16];
      window_low    <= res[15:8];
      check_byte    <= res[7:0];
      crc_ok        <= crc_ok_next;
    end
  end

endmodule

// File: sv/pdcrc_checker.sv
// ----------------------------------------------------------------------------
// pdcrc_checker
// Port-level checks for the packet descrambler, bound to the top level.
// ----------------------------------------------------------------------------
module pdcrc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [23:0] serial_number,
  input logic [7:0]  check_byte,
  input logic        crc_ok
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(serial_number)
      && $stable(check_byte) && $stable(crc_ok))
    else $error("stalled result changed");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output free");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) ##1 !(out_valid && out_stall) |=> out_valid)
    else $error("accepted transaction not delivered");

endmodule

bind rf_packet_descrambler_crc12 pdcrc_checker u_pdcrc_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .serial_number (serial_number),
  .check_byte    (check_byte),
  .crc_ok        (crc_ok)
);

// File: dv/tb_rf_packet_descrambler_crc12.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rf_packet_descrambler_crc12
// Self-checking bench for the radio packet descrambler with CRC-12 check.
// Every accepted block is decoded by a behavioural model in the bench and the
// result queued; each output transaction is compared field by field with the
// oldest queued result. Stimulus mixes raw random blocks with blocks built by
// running chosen payloads (most of them carrying a correct CRC) backwards
// through the scrambler, under three idling profiles and one long output hold.
// ----------------------------------------------------------------------------
module tb_rf_packet_descrambler_crc12;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 80;
  localparam int unsigned RandomPerPhase = 177;
  localparam pdcrc_pkg::byte_t RotCases [4] = '{8'd0, 8'd47, 8'd48, 8'd255};

  typedef struct packed {
    logic [23:0]      serial;
    pdcrc_pkg::byte_t status;
    pdcrc_pkg::byte_t win_hi;
    pdcrc_pkg::byte_t win_lo;
    pdcrc_pkg::byte_t check;
    logic             crc_good;
  } decoded_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [55:0] cipher_block = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [23:0] serial_number;
  logic [7:0]  status_byte;
  logic [7:0]  window_high;
  logic [7:0]  window_low;
  logic [7:0]  check_byte;
  logic        crc_ok;

  pdcrc_pkg::block_t blocks_to_send[$];
  decoded_t          decodes_due[$];
  decoded_t          oldest;

  int          sender_idle_pct = 0;
  int          receiver_idle_pct = 0;
  int          hold_left = 0;
  logic        hold_go = 1'b0;
  int unsigned cycle_count = 0;
  int          mismatches = 0;
  int          blocks_sent = 0;
  int          results_seen = 0;
  int          crc_good_seen = 0;
  int          input_stall_cycles = 0;

  rf_packet_descrambler_crc12 dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .cipher_block  (cipher_block),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .serial_number (serial_number),
    .status_byte   (status_byte),
    .window_high   (window_high),
    .window_low    (window_low),
    .check_byte    (check_byte),
    .crc_ok        (crc_ok)
  );

  always #5 clk = ~clk;

  function automatic logic [pdcrc_pkg::CrcW-1:0] crc12_of(
      logic [pdcrc_pkg::CrcBits-1:0] bits);
    logic [pdcrc_pkg::CrcW-1:0] r;
    r = '0;
    for (int i = pdcrc_pkg::CrcBits - 1; i >= 0; i--) begin
      if (bits[i] != r[pdcrc_pkg::CrcW-1]) begin
        r = (r << 1) ^ pdcrc_pkg::CrcPoly;
      end else begin
        r = r << 1;
      end
    end
    return r;
  endfunction

  function automatic pdcrc_pkg::block_t swap_nib(pdcrc_pkg::block_t v, int unsigned ia,
                                                 bit ha, int unsigned ib, bit hb);
    int unsigned pa;
    int unsigned pb;
    logic [3:0]  t;
    pa = (6 - ia) * 8 + (ha ? 4 : 0);
    pb = (6 - ib) * 8 + (hb ? 4 : 0);
    t = v[pa +: 4];
    v[pa +: 4] = v[pb +: 4];
    v[pb +: 4] = t;
    return v;
  endfunction

  // Pattern comes from the low nibble of byte 6, which no pattern touches,
  // so applying it twice restores the block.
  function automatic pdcrc_pkg::block_t shuffle_nibbles(pdcrc_pkg::block_t v);
    case ({v[3], v[1]})
      pdcrc_pkg::SwapLow: begin
        v = swap_nib(v, 6, 1, 0, 0);
        v = swap_nib(v, 5, 0, 3, 0);
      end
      pdcrc_pkg::SwapBit1: begin
        v = swap_nib(v, 6, 1, 0, 1);
        v = swap_nib(v, 4, 1, 1, 1);
      end
      pdcrc_pkg::SwapBit3: begin
        v = swap_nib(v, 6, 1, 5, 1);
        v = swap_nib(v, 5, 0, 2, 1);
      end
      default: begin
        v = swap_nib(v, 6, 1, 1, 0);
        v = swap_nib(v, 4, 1, 3, 0);
      end
    endcase
    return v;
  endfunction

  function automatic decoded_t descramble(pdcrc_pkg::block_t x);
    pdcrc_pkg::block_t           v;
    logic [pdcrc_pkg::WordW-1:0] w;
    int unsigned                 rot;
    decoded_t                    d;
    v = x ^ pdcrc_pkg::FirstMask[{x[52], x[34], x[12]}];
    v = shuffle_nibbles(v);
    rot = v[7:0] % pdcrc_pkg::WordW;
    w = v[55:8];
    w = (w >> rot) | (w << (pdcrc_pkg::WordW - rot));
    v = {w, v[7:0]} ^ pdcrc_pkg::FinalMask;
    d.serial   = v[55:32];
    d.status   = v[31:24];
    d.win_hi   = v[23:16];
    d.win_lo   = v[15:8];
    d.check    = v[7:0];
    d.crc_good = (crc12_of(v[55:12]) == v[11:0]);
    return d;
  endfunction

  // Inverse of the decode. Every first mask is clear at the select bits, so
  // the select seen here is the one the decoder will see.
  function automatic pdcrc_pkg::block_t scramble(pdcrc_pkg::block_t plain);
    pdcrc_pkg::block_t           v;
    logic [pdcrc_pkg::WordW-1:0] w;
    int unsigned                 rot;
    v = plain ^ pdcrc_pkg::FinalMask;
    rot = v[7:0] % pdcrc_pkg::WordW;
    w = v[55:8];
    w = (w << rot) | (w >> (pdcrc_pkg::WordW - rot));
    v = shuffle_nibbles({w, v[7:0]});
    return v ^ pdcrc_pkg::FirstMask[{v[52], v[34], v[12]}];
  endfunction

  function automatic pdcrc_pkg::block_t random_block();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[55:0];
  endfunction

  function automatic pdcrc_pkg::block_t crc_clean_payload();
    pdcrc_pkg::block_t d;
    d = random_block();
    d[11:0] = crc12_of(d[55:12]);
    return d;
  endfunction

  task automatic queue_random(int count);
    pdcrc_pkg::block_t d;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4: blocks_to_send.push_back(scramble(crc_clean_payload()));
        5: begin
          d = crc_clean_payload();
          d[$urandom_range(55)] ^= 1'b1;
          blocks_to_send.push_back(scramble(d));
        end
        default: blocks_to_send.push_back(random_block());
      endcase
    end
  endtask

  task automatic check_field(string name, logic [23:0] want, logic [23:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        decodes_due.push_back(descramble(cipher_block));
        blocks_sent++;
      end
      if (in_valid && in_stall) begin
        input_stall_cycles++;
      end
      if (!in_valid || !in_stall) begin
        if (blocks_to_send.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          in_valid     <= 1'b1;
          cipher_block <= blocks_to_send.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long output hold
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_go) begin
      hold_left <= HoldCycles;
    end
  end

  // Monitor
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (crc_ok === 1'b1) begin
          crc_good_seen++;
        end
        if (decodes_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, actual serial %0h", $time,
                   serial_number);
        end else begin
          oldest = decodes_due.pop_front();
          check_field("serial_number", oldest.serial, serial_number);
          check_field("status_byte", 24'(oldest.status), 24'(status_byte));
          check_field("window_high", 24'(oldest.win_hi), 24'(window_high));
          check_field("window_low", 24'(oldest.win_lo), 24'(window_low));
          check_field("check_byte", 24'(oldest.check), 24'(check_byte));
          check_field("crc_ok", 24'(oldest.crc_good), 24'(crc_ok));
        end
      end
      out_stall <= (hold_left != 0) || ($urandom_range(99) < receiver_idle_pct);
    end
  end

  initial begin
    pdcrc_pkg::block_t d;
    sender_idle_pct   = 22;
    receiver_idle_pct = 82;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    blocks_to_send.push_back('0);
    blocks_to_send.push_back('1);
    // every mask select, each swap pattern twice
    for (int s = 0; s < 8; s++) begin
      d = random_block();
      d[52] = s[2];
      d[34] = s[1];
      d[12] = s[0];
      d[3]  = pdcrc_pkg::FirstMask[s][3] ^ s[1];
      d[1]  = pdcrc_pkg::FirstMask[s][1] ^ s[0];
      blocks_to_send.push_back(d);
    end
    // rotation count extremes
    for (int k = 0; k < 4; k++) begin
      d = random_block();
      d[7:0] = RotCases[k] ^ pdcrc_pkg::FinalMask[7:0];
      blocks_to_send.push_back(scramble(d));
    end
    // good CRC payloads and one with a corrupted CRC
    blocks_to_send.push_back(scramble('0));
    blocks_to_send.push_back(scramble(crc_clean_payload()));
    d = '1;
    d[11:0] = crc12_of(d[55:12]);
    blocks_to_send.push_back(scramble(d));
    d = crc_clean_payload();
    d[0] = ~d[0];
    blocks_to_send.push_back(scramble(d));

    queue_random(RandomPerPhase);
    while (blocks_to_send.size() != 0) @(negedge clk);

    sender_idle_pct   = 82;
    receiver_idle_pct = 22;
    queue_random(RandomPerPhase);
    while (blocks_to_send.size() != 0) @(negedge clk);

    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    queue_random(RandomPerPhase);
    hold_go = 1'b1;
    @(negedge clk);
    hold_go = 1'b0;

    while (blocks_to_send.size() != 0 || in_valid || decodes_due.size() != 0) @(negedge clk);
    repeat (10) @(posedge clk);

    $display("Run covered %0d blocks and %0d results, %0d of them with a good CRC.",
             blocks_sent, results_seen, crc_good_seen);
    $display("Input held back by the block for %0d cycles; %0d mismatches.",
             input_stall_cycles, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
